### rtl/port_timeout_table_macros.svh
// assertion macros shared by the port timeout table modules
// expects clk_i and rst_ni in the scope of each use
`ifndef PORT_TIMEOUT_TABLE_MACROS_SVH
`define PORT_TIMEOUT_TABLE_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ptt_pkg.sv
// types and constants for the port timeout table
// no dependencies
package ptt_pkg;

  localparam int unsigned TimeW = 63;
  localparam int unsigned PortFieldW = 16;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_ABSENT    = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_FIRED     = 3'd5;
  localparam logic [2:0] ST_NONE      = 3'd6;

  localparam logic [TimeW-1:0] NONE_DEADLINE = {TimeW{1'b1}};

  typedef struct packed {
    logic [1:0]            mode;
    logic [PortFieldW-1:0] port_id;
    logic [TimeW-1:0]      deadline;
    logic [TimeW-1:0]      now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [PortFieldW-1:0] fired_port;
    logic [TimeW-1:0]      earliest_deadline;
    logic                  last;
  } result_t;

endpackage

### rtl/ptt_mem.sv
// entry store: port and deadline of each table slot
// single write port, one registered read port; uses no package
module ptt_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WORD_W = 79
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WORD_W-1:0]                     wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WORD_W-1:0]                     rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ptt_ctrl.sv
// sequencer of the port timeout table: scans the entry store, keeps valid bits
// and the earliest deadline, and builds result beats; uses ptt_pkg and the macros header
`include "port_timeout_table_macros.svh"

module ptt_ctrl #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned PORT_W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptt_pkg::item_t      in_item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ptt_pkg::result_t    res_o,
  output logic                mem_we_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr_o,
  output logic [PORT_W+ptt_pkg::TimeW-1:0] mem_wdata_o,
  output logic                mem_re_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr_o,
  input  logic [PORT_W+ptt_pkg::TimeW-1:0] mem_rdata_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW = PORT_W + ptt_pkg::TimeW;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_FINISH  = 3'd3;
  localparam logic [2:0] S_PUT     = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [1:0]                  mode_q, mode_d;
  logic [PORT_W-1:0]           port_q, port_d;
  logic [ptt_pkg::TimeW-1:0]   val_q, val_d;
  logic [DEPTH-1:0]            valid_q, valid_d;
  logic [DEPTH-1:0]            fire_q, fire_d;
  logic [DEPTH-1:0]            fire_rest;
  logic [ptt_pkg::TimeW-1:0]   earliest_q, earliest_d;
  logic [ptt_pkg::TimeW-1:0]   min_q, min_d;
  logic                        hit_q, hit_d;
  logic [AW-1:0]               hit_idx_q, hit_idx_d;
  logic                        free_q, free_d;
  logic [AW-1:0]               free_idx_q, free_idx_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic                        dv_q, dv_d;
  logic [AW-1:0]               cmp_idx_q, cmp_idx_d;
  logic [2:0]                  status_q, status_d;
  logic [ptt_pkg::PortFieldW-1:0] out_port_q, out_port_d;
  logic                        last_q, last_d;

  logic [PORT_W-1:0]           rd_port;
  logic [ptt_pkg::TimeW-1:0]   rd_dl;

  assign rd_port = mem_rdata_i[PORT_W-1:0];
  assign rd_dl   = mem_rdata_i[WW-1:PORT_W];

  always_comb begin
    fire_rest = fire_q;
    fire_rest[idx_q] = 1'b0;
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    port_d     = port_q;
    val_d      = val_q;
    valid_d    = valid_q;
    fire_d     = fire_q;
    earliest_d = earliest_q;
    min_d      = min_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    idx_d      = idx_q;
    dv_d       = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    status_d   = status_q;
    out_port_d = out_port_q;
    last_d     = last_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = hit_idx_q;
    mem_wdata_o = {val_q, port_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;

    // entry compare, in the cycle after its read
    if (dv_q) begin
      if (valid_q[cmp_idx_q]) begin
        if (mode_q != ptt_pkg::MODE_TICK && rd_port == port_q) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
        end else if (mode_q == ptt_pkg::MODE_TICK && rd_dl <= val_q) begin
          fire_d[cmp_idx_q] = 1'b1;
        end else if (rd_dl < min_q) begin
          min_d = rd_dl;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d = in_item_i.mode;
          port_d = in_item_i.port_id[PORT_W-1:0];
          val_d  = (in_item_i.mode == ptt_pkg::MODE_SET) ? in_item_i.deadline
                                                        : in_item_i.now_ms;
          hit_d  = 1'b0;
          free_d = 1'b0;
          fire_d = '0;
          min_d  = ptt_pkg::NONE_DEADLINE;
          idx_d  = '0;
          case (in_item_i.mode)
            ptt_pkg::MODE_SET, ptt_pkg::MODE_CANCEL: begin
              state_d = S_SCAN;
            end
            ptt_pkg::MODE_TICK: begin
              if (earliest_q > in_item_i.now_ms) begin
                status_d   = ptt_pkg::ST_NONE;
                out_port_d = '0;
                last_d     = 1'b1;
                state_d    = S_PUT;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_re_o  = 1'b1;
        dv_d      = 1'b1;
        cmp_idx_d = idx_q;
        if (idx_q == AW'(DEPTH - 1)) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        last_d     = 1'b1;
        out_port_d = ptt_pkg::PortFieldW'(port_q);
        state_d    = S_PUT;
        case (mode_q)
          ptt_pkg::MODE_SET: begin
            if (hit_q || free_q) begin
              mem_we_o = 1'b1;
              if (val_q < earliest_q) begin
                earliest_d = val_q;
              end
              if (hit_q) begin
                status_d = ptt_pkg::ST_UPDATED;
              end else begin
                mem_waddr_o         = free_idx_q;
                valid_d[free_idx_q] = 1'b1;
                status_d            = ptt_pkg::ST_INSERTED;
              end
            end else begin
              status_d = ptt_pkg::ST_FULL;
            end
          end
          ptt_pkg::MODE_CANCEL: begin
            if (hit_q) begin
              valid_d[hit_idx_q] = 1'b0;
              earliest_d         = min_q;
              status_d           = ptt_pkg::ST_CANCELLED;
            end else begin
              status_d = ptt_pkg::ST_ABSENT;
            end
          end
          ptt_pkg::MODE_TICK: begin
            valid_d    = valid_q & ~fire_q;
            earliest_d = min_q;
            if (fire_q == '0) begin
              status_d   = ptt_pkg::ST_NONE;
              out_port_d = '0;
            end else begin
              idx_d   = '0;
              state_d = S_EMIT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_PUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = last_q ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (fire_q[idx_q]) begin
          mem_re_o      = 1'b1;
          fire_d[idx_q] = 1'b0;
          last_d        = (fire_rest == '0);
          state_d       = S_EMIT_RD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_EMIT_RD: begin
        status_d   = ptt_pkg::ST_FIRED;
        out_port_d = ptt_pkg::PortFieldW'(rd_port);
        state_d    = S_PUT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      fire_q     <= '0;
      earliest_q <= ptt_pkg::NONE_DEADLINE;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      dv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      fire_q     <= fire_d;
      earliest_q <= earliest_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      dv_q       <= dv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    port_q     <= port_d;
    val_q      <= val_d;
    min_q      <= min_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    status_q   <= status_d;
    out_port_q <= out_port_d;
    last_q     <= last_d;
  end

  assign res_o.status            = status_q;
  assign res_o.fired_port        = out_port_q;
  assign res_o.earliest_deadline = earliest_q;
  assign res_o.last              = last_q;

  `PTT_ASSERT_IMP(a_no_rw_overlap, mem_we_o, !mem_re_o, "store read and written together")
  `PTT_ASSERT_IMP(a_emit_has_work, state_q == S_EMIT, fire_q != '0, "emit with no fired entry")
  `PTT_ASSERT_IMP(a_last_drains, (state_q == S_PUT) && last_q, fire_q == '0, "fired entries left")
  `PTT_ASSERT_NEXT(a_set_lowers, (state_q == S_FINISH) && (mode_q == ptt_pkg::MODE_SET), earliest_q <= $past(earliest_q), "set raised earliest deadline")

endmodule

### rtl/port_timeout_table.sv
// Port timeout table. Holds up to TABLE_DEPTH port deadlines in a store with one write
// port and one registered read port, scanned one entry per cycle. A set or cancel beat,
// and a tick that has reached the earliest deadline, scans every slot, then passes the
// drain and finish states before its result is put out; a tick that fires then walks
// the slots and reads each fired port back from the store before putting it out. A tick
// ahead of the earliest deadline skips the scan and goes straight to its result. A
// stalled output holds the result back. One beat is worked on at a time; a finished
// result sits in the output register while the next beat is taken. Fired ports leave
// in ascending slot order, tlast on the final one.
`include "port_timeout_table_macros.svh"

module port_timeout_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned PORT_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [143:0] s_axis_tdata_i,   // port_id[15:0], deadline[78:16], now_ms[141:79]
  input  logic [1:0]   s_axis_tuser_i,   // mode
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [79:0]  m_axis_tdata_o,   // fired_port[15:0], earliest_deadline[78:16]
  output logic [2:0]   m_axis_tuser_o,   // status
  output logic         m_axis_tlast_o
);

  localparam int unsigned PORT_W = (PORT_BITS < ptt_pkg::PortFieldW) ? PORT_BITS
                                                                     : ptt_pkg::PortFieldW;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned WW = PORT_W + ptt_pkg::TimeW;

  ptt_pkg::item_t   item;
  ptt_pkg::result_t res;
  logic             res_valid, res_ready;
  ptt_pkg::result_t out_q;
  logic             out_valid_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  assign item.mode     = s_axis_tuser_i;
  assign item.port_id  = s_axis_tdata_i[15:0];
  assign item.deadline = s_axis_tdata_i[78:16];
  assign item.now_ms   = s_axis_tdata_i[141:79];

  ptt_ctrl #(
    .DEPTH  (TABLE_DEPTH),
    .PORT_W (PORT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ptt_mem #(
    .DEPTH  (TABLE_DEPTH),
    .WORD_W (WW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.earliest_deadline, out_q.fired_port};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

  `PTT_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid_i && s_axis_tready_o,
                   !s_axis_tready_o, "second beat taken while busy")

endmodule
